>>> sv/assert_macros.svh
// Assertion macros used by the RTL core of the aim-angle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_IMPLY(name, clk, rst, a, c, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Implication after a fixed number of cycles, checked outside reset.
`define CHK_DELAY(name, clk, rst, a, n, c, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (c)) else $error(msg);

`endif

>>> sv/vtpy_pkg.sv
// Types, constants and CORDIC helper functions for the aim-angle block.
`timescale 1ns / 1ps
package vtpy_pkg;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [31:0] eye_dx;
    logic signed [31:0] eye_dy;
    logic signed [31:0] eye_dz;
  } request_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               degenerate;
  } response_t;

  // Flags that ride alongside each word through the pipeline.
  typedef struct packed {
    logic degen;
    logic vert;
    logic dz_pos;
  } flags_t;

  // One CORDIC pipeline stage.
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [33:0] z;
    logic signed [63:0] ymul;
    logic signed [15:0] yaw;
    flags_t             flags;
  } stage_t;

  localparam int ATAN_ENTRIES = 32;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629714;
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;
  localparam logic [16:0] PITCH_LIMIT = 17'd11520;
  localparam logic [16:0] YAW_LIMIT = 17'd23040;

  // Arctangent of 2^-i in radians, Q30, rounded to nearest.
  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      31: v = 34'sd0;
      default: v = 34'sd1 <<< (30 - i);
    endcase
    return v;
  endfunction

  // CORDIC gain in Q24 for n iterations, worked out at elaboration.
  function automatic longint unsigned cordic_gain(input int n);
    longint unsigned p;
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    int i;
    p = 64'd1 << 30;
    for (i = 0; i < ATAN_ENTRIES; i++) begin
      if (i < n) p = p + (p >> (2 * i));
    end
    v = p << 18;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    for (i = 0; i < ATAN_ENTRIES; i++) begin
      if (b > v) b = b >> 2;
    end
    for (i = 0; i < ATAN_ENTRIES; i++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // One vectoring micro-rotation toward the x axis.
  function automatic stage_t cordic_iter(input stage_t s, input int i);
    stage_t o;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    o = s;
    xs = s.x >>> i;
    ys = s.y >>> i;
    if (!s.y[63]) begin
      o.x = s.x + ys;
      o.y = s.y - xs;
      o.z = s.z + atan_q30(i);
    end else begin
      o.x = s.x - ys;
      o.y = s.y + xs;
      o.z = s.z - atan_q30(i);
    end
    return o;
  endfunction

  // Magnitude of a Q30 angle times degrees per radian.
  function automatic logic [62:0] deg_product(input logic signed [33:0] z);
    logic [32:0] mag;
    mag = z[33] ? 33'(-z) : 33'(z);
    return 63'(mag) * 63'(DEG_PER_RAD_Q24);
  endfunction

  // Rounds a degree product to Q7 and clamps it to a limit.
  function automatic logic [16:0] deg_round(input logic [62:0] prod, input logic [16:0] lim);
    logic [63:0] sum;
    logic [16:0] r;
    sum = {1'b0, prod} + (64'd1 << 46);
    r = sum[63:47];
    return (r > lim) ? lim : r;
  endfunction

endpackage

>>> sv/vector_to_pitch_yaw_core.sv
// Pipelined aim-angle unit: pitch and yaw from a target, base and eye offset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A request word is taken at each rising edge where start is high and busy
// is low. busy stays low: the pipeline takes a new word in every cycle.
// Each request gives one response word, shown on response for exactly one
// cycle while done is high. Responses leave in request order at one per
// cycle; the receiver cannot stall them, so none is ever held back.
// The pipeline forms the difference vector, runs CORDIC_STEPS registered
// vectoring stages for yaw, converts yaw to degrees, then runs a second
// chain of CORDIC_STEPS stages for pitch; the two CORDIC chains set the
// latency. A zero vector sets degenerate with zero angles; a vertical
// vector gives the pitch limit directly.
// Reset clears the valid bits only, so words in flight are dropped and
// done stays low until new requests have passed through.
module vector_to_pitch_yaw_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  vtpy_pkg::request_t  request,
  output logic                done,
  output vtpy_pkg::response_t response
);
  import vtpy_pkg::*;

  localparam int N = CORDIC_STEPS;
  localparam int LAT = 2 * N + 6;
  localparam logic signed [25:0] GAIN = 26'(cordic_gain(N));

  logic signed [34:0] dx, dy, dz;
  logic v1;

  stage_t p1 [0:N];
  logic   p1_v [0:N];
  stage_t p2 [0:N];
  logic   p2_v [0:N];

  logic [62:0] yaw_prod;
  stage_t      ya;
  logic        ya_v;
  logic [62:0] pitch_prod;
  logic        pitch_neg;
  flags_t      pc_flags;
  logic signed [15:0] pc_yaw;
  logic        pc_v;

  stage_t pre;
  logic [16:0] yaw_mag;
  logic [16:0] pitch_mag;

  logic angles_zero;
  logic angles_in_range;

  assign busy = 1'b0;

  // Difference vector, exact in 35 bits.
  always_ff @(posedge clk) begin
    dx <= 35'(request.target_x) - (35'(request.base_x) + 35'(request.eye_dx));
    dy <= 35'(request.target_y) - (35'(request.base_y) + 35'(request.eye_dy));
    dz <= 35'(request.target_z) - (35'(request.base_z) + 35'(request.eye_dz));
  end

  // Quarter-turn pre-rotation brings x into the right half plane.
  always_comb begin
    pre.x = 64'(dx) <<< 24;
    pre.y = 64'(dy) <<< 24;
    pre.z = '0;
    if (dx[34]) begin
      if (!dy[34]) begin
        pre.x = 64'(dy) <<< 24;
        pre.y = -(64'(dx) <<< 24);
        pre.z = HALF_PI_Q30;
      end else begin
        pre.x = -(64'(dy) <<< 24);
        pre.y = 64'(dx) <<< 24;
        pre.z = -HALF_PI_Q30;
      end
    end
    pre.ymul = 64'(dz * 61'(GAIN));
    pre.yaw = '0;
    pre.flags.degen = (dx == '0) && (dy == '0) && (dz == '0);
    pre.flags.vert = (dx == '0) && (dy == '0);
    pre.flags.dz_pos = !dz[34] && (dz != '0);
  end

  always_ff @(posedge clk) begin
    p1[0] <= pre;
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_yaw
      always_ff @(posedge clk) begin
        p1[gi+1] <= cordic_iter(p1[gi], gi);
      end
    end
    for (gi = 0; gi < N; gi++) begin : g_pitch
      always_ff @(posedge clk) begin
        p2[gi+1] <= cordic_iter(p2[gi], gi);
      end
    end
  endgenerate

  // Yaw to degrees, in parallel with loading the pitch chain.
  always_ff @(posedge clk) begin
    yaw_prod <= deg_product(p1[N].z);
    ya <= p1[N];
  end

  assign yaw_mag = deg_round(yaw_prod, YAW_LIMIT);

  always_ff @(posedge clk) begin
    p2[0].x <= ya.x;
    p2[0].y <= ya.ymul;
    p2[0].z <= '0;
    p2[0].ymul <= ya.ymul;
    p2[0].yaw <= ya.z[33] ? -16'(yaw_mag) : 16'(yaw_mag);
    p2[0].flags <= ya.flags;
  end

  always_ff @(posedge clk) begin
    pitch_prod <= deg_product(p2[N].z);
    pitch_neg <= p2[N].z[33];
    pc_flags <= p2[N].flags;
    pc_yaw <= p2[N].yaw;
  end

  assign pitch_mag = deg_round(pitch_prod, PITCH_LIMIT);

  always_ff @(posedge clk) begin
    if (pc_flags.degen) begin
      response.pitch_angle <= '0;
      response.yaw_angle <= '0;
      response.degenerate <= 1'b1;
    end else if (pc_flags.vert) begin
      response.pitch_angle <= pc_flags.dz_pos ? -15'(PITCH_LIMIT) : 15'(PITCH_LIMIT);
      response.yaw_angle <= '0;
      response.degenerate <= 1'b0;
    end else begin
      // Pitch is the negated elevation angle.
      response.pitch_angle <= pitch_neg ? 15'(pitch_mag) : -15'(pitch_mag);
      response.yaw_angle <= pc_yaw;
      response.degenerate <= 1'b0;
    end
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      ya_v <= 1'b0;
      pc_v <= 1'b0;
      done <= 1'b0;
      for (int k = 0; k <= N; k++) begin
        p1_v[k] <= 1'b0;
        p2_v[k] <= 1'b0;
      end
    end else begin
      v1 <= start && !busy;
      p1_v[0] <= v1;
      for (int k = 0; k < N; k++) begin
        p1_v[k+1] <= p1_v[k];
        p2_v[k+1] <= p2_v[k];
      end
      ya_v <= p1_v[N];
      p2_v[0] <= ya_v;
      pc_v <= p2_v[N];
      done <= pc_v;
    end
  end

  assign angles_zero = (response.pitch_angle == '0) && (response.yaw_angle == '0);
  assign angles_in_range = ($signed(response.pitch_angle) <= 15'sd11520) &&
                           ($signed(response.pitch_angle) >= -15'sd11520) &&
                           ($signed(response.yaw_angle) <= 16'sd23040) &&
                           ($signed(response.yaw_angle) >= -16'sd23040);

  `CHK_DELAY(a_latency, clk, rst, start && !busy, LAT, done, "response word missing")
  `CHK_IMPLY(a_degen_zero, clk, rst, done && response.degenerate, angles_zero, "degenerate word with nonzero angle")
  `CHK_IMPLY(a_range, clk, rst, done, angles_in_range, "angle out of range")

endmodule

>>> tb/tb.sv
// Testbench for the pipelined aim-angle unit, with a built-in angle predictor.
`timescale 1ns / 1ps
module tb;
  import vtpy_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 6;
  localparam int N_RANDOM = 1530;
  localparam longint PI_Q28 = 64'sd843314857;
  localparam longint unsigned DEG_Q24 = 64'd961263669;
  localparam longint PITCH_MAX = 11520;
  localparam longint YAW_MAX = 23040;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  request_t request = '0;
  response_t response;

  request_t pending_q[$];
  response_t angles_q[$];
  longint atan_tab[32];
  longint gain;
  int words_sent = 0;
  int words_checked = 0;
  int errors = 0;
  int degen_seen = 0;
  int vert_seen = 0;
  int gap = 0;
  int drain_at = 0;
  bit drained = 1'b0;

  vector_to_pitch_yaw_core #(.CORDIC_STEPS(STEPS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .response(response)
  );

  always #5 clk = ~clk;

  // Arctangent series in Q62, rounded into Q30; entry 0 is pi/4.
  function automatic void build_tables();
    longint s;
    longint unsigned p;
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    int e;
    atan_tab[0] = PI_Q28;
    for (int i = 1; i < 32; i++) begin
      s = 0;
      for (int k = 0; k < 64; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e < 0) break;
        if (k % 2 == 1) s = s - longint'((64'd1 << e) / (2 * k + 1));
        else s = s + longint'((64'd1 << e) / (2 * k + 1));
      end
      atan_tab[i] = (s + (64'sd1 <<< 31)) >>> 32;
    end
    p = 64'd1 << 30;
    for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
    v = p << 18;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    gain = longint'(r);
  endfunction

  function automatic void rotate_to_axis(inout longint x, inout longint y, inout longint z);
    longint xs;
    longint ys;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end
    end
  endfunction

  function automatic longint to_degrees(longint z, longint lim);
    longint unsigned mag;
    longint unsigned r;
    mag = (z < 0) ? longint'(-z) : z;
    r = (mag * DEG_Q24 + (64'd1 << 46)) >> 47;
    if (r > lim) r = lim;
    return (z < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic response_t aim_angles(request_t q);
    response_t a;
    longint dx, dy, dz, x, y, z, t, pitch, yaw;
    dx = longint'(q.target_x) - (longint'(q.base_x) + longint'(q.eye_dx));
    dy = longint'(q.target_y) - (longint'(q.base_y) + longint'(q.eye_dy));
    dz = longint'(q.target_z) - (longint'(q.base_z) + longint'(q.eye_dz));
    pitch = 0;
    yaw = 0;
    a.degenerate = 1'b0;
    if (dx == 0 && dy == 0 && dz == 0) begin
      a.degenerate = 1'b1;
    end else if (dx == 0 && dy == 0) begin
      pitch = (dz > 0) ? -PITCH_MAX : PITCH_MAX;
    end else begin
      x = dx <<< 24;
      y = dy <<< 24;
      z = 0;
      // Left half plane: turn a quarter first so the CORDIC converges.
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = 2 * PI_Q28;
        end else begin
          x = -y; y = t; z = -2 * PI_Q28;
        end
      end
      rotate_to_axis(x, y, z);
      yaw = to_degrees(z, YAW_MAX);
      y = dz * gain;
      z = 0;
      rotate_to_axis(x, y, z);
      pitch = -to_degrees(z, PITCH_MAX);
    end
    a.pitch_angle = pitch[14:0];
    a.yaw_angle = yaw[15:0];
    return a;
  endfunction

  function automatic request_t make_word(int dx, int dy, int dz, int bx, int by, int bz,
                                         int ex, int ey, int ez);
    request_t q;
    q.base_x = bx; q.base_y = by; q.base_z = bz;
    q.eye_dx = ex; q.eye_dy = ey; q.eye_dz = ez;
    q.target_x = bx + ex + dx;
    q.target_y = by + ey + dy;
    q.target_z = bz + ez + dz;
    return q;
  endfunction

  function automatic int small_val(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Driver: one request word per accepted handshake, with random idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        angles_q.push_back(aim_angles(request));
        words_sent++;
      end
      if (!drained && words_sent >= drain_at && angles_q.size() == 0) drained = 1'b1;
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (!drained && words_sent >= drain_at) begin
        start <= 1'b0;
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
      end else if (pending_q.size() > 200 && $urandom_range(9) == 0) begin
        gap = $urandom_range(6);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        request <= pending_q.pop_front();
      end
    end
  end

  // Monitor: every done cycle carries one response word.
  always @(posedge clk) begin
    response_t want;
    if (!rst && done) begin
      if (angles_q.size() == 0) begin
        $error("response word with nothing expected");
        errors++;
      end else begin
        want = angles_q.pop_front();
        words_checked++;
        if (want.degenerate) degen_seen++;
        if (!want.degenerate && want.yaw_angle == 0 &&
            (want.pitch_angle == 15'(PITCH_MAX) || want.pitch_angle == 15'(-PITCH_MAX)))
          vert_seen++;
        if (response.pitch_angle !== want.pitch_angle) begin
          $error("pitch_angle expected %0d got %0d", want.pitch_angle, response.pitch_angle);
          errors++;
        end
        if (response.yaw_angle !== want.yaw_angle) begin
          $error("yaw_angle expected %0d got %0d", want.yaw_angle, response.yaw_angle);
          errors++;
        end
        if (response.degenerate !== want.degenerate) begin
          $error("degenerate expected %0d got %0d", want.degenerate, response.degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    request_t q;
    int mode;
    build_tables();
    // Directed words: zero vector, vertical, axes, negative x axis, extremes.
    pending_q.push_back(make_word(0, 0, 0, 100, -200, 300, 5, 6, 7));
    pending_q.push_back(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_word(0, 0, 256, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_word(0, 0, -1, 10, 10, 10, 0, 0, 0));
    pending_q.push_back(make_word(1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_word(-1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_word(-5000, 0, 300, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_word(0, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_word(0, -1, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_word(-7, -7, 7, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_word(3, 4, -12, 0, 0, 0, 0, 0, 0));
    q = '{default: 32'sh7fffffff};
    pending_q.push_back(q);
    q = '{default: 32'sh80000000};
    pending_q.push_back(q);
    // Target at one corner, eye at the far one: widest differences.
    q = '{target_x: 32'sh7fffffff, target_y: 32'sh7fffffff, target_z: 32'sh7fffffff,
          default: 32'sh80000000};
    pending_q.push_back(q);
    q = '{target_x: 32'sh80000000, target_y: 32'sh80000000, target_z: 32'sh80000000,
          default: 32'sh7fffffff};
    pending_q.push_back(q);
    q = '{target_x: 32'sh80000000, target_y: 32'sh7fffffff, target_z: 32'sh80000000,
          default: 32'sh7fffffff};
    pending_q.push_back(q);
    q = '{target_x: 32'sh80000000, target_y: 0, target_z: 32'sh7fffffff,
          base_y: 0, eye_dy: 0, default: 32'sh7fffffff};
    pending_q.push_back(q);
    q = '{target_x: 0, target_y: 0, target_z: 32'sh80000000, default: 32'sh7fffffff};
    pending_q.push_back(q);
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(9);
      case (mode)
        0, 1, 2: begin
          q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        end
        3: q = make_word(0, 0, $urandom_range(1) ? small_val(1000) : int'($urandom),
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        4: q = make_word(-int'($urandom_range(1 << 30)), 0, small_val(1 << 20),
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        5: q = make_word(small_val(3), small_val(3), small_val(3),
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: q = make_word(small_val(1 << 16), small_val(1 << 16), small_val(1 << 16),
                               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      pending_q.push_back(q);
    end
    // Pause the feed once until the pipeline has emptied.
    drain_at = pending_q.size() / 2;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    while (angles_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d of %0d words: %0d zero vectors, %0d vertical vectors,",
             words_checked, words_sent, degen_seen, vert_seen);
    $display("plus axis, negative-x, extreme and random geometries under idle bursts.");
    if (errors == 0 && angles_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
